### sv/fnrs_pkg.sv
// Shared types and constants for the first non-repeating symbol block.
package fnrs_pkg;

  localparam int SYM_W   = 8;
  localparam int ALPHA   = 256;
  localparam int ADDR_W  = $clog2(ALPHA);
  localparam int LEVEL_W = ADDR_W + 1;
  localparam int CNT_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX   = 2'd3;
  localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
  localparam logic [SYM_W-1:0] NOT_FOUND = 8'd35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_QRD,
    ST_CRD,
    ST_TEST,
    ST_DONE
  } fnrs_state_t;

  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
  } fnrs_cnt_ctl_t;

  typedef struct packed {
    logic             clr;
    logic             push;
    logic [SYM_W-1:0] push_data;
    logic             pop;
    logic             rd_en;
  } fnrs_q_ctl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SYM_W-1:0]   rd_data;
  } fnrs_q_sts_t;

endpackage

### sv/fnrs_count_mem.sv
// Occurrence count memory with per-entry valid bits, so that a clear needs no sweep.
module fnrs_count_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fnrs_pkg::fnrs_cnt_ctl_t ctl,
  output logic [fnrs_pkg::CNT_W-1:0] rd_data
);
  import fnrs_pkg::*;

  logic [CNT_W-1:0] cnt_mem [ALPHA];
  logic [ALPHA-1:0] valid_r;
  logic [CNT_W-1:0] rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cnt_mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= cnt_mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      // a read issued together with a clear sees the cleared entry
      if (ctl.rd_en) begin
        rd_vld_r <= valid_r[ctl.rd_addr] && !ctl.clr;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### sv/fnrs_queue.sv
// Order queue: symbols in first-occurrence order, with head, tail and level.
module fnrs_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fnrs_pkg::fnrs_q_ctl_t ctl,
  output fnrs_pkg::fnrs_q_sts_t sts
);
  import fnrs_pkg::*;

  logic [SYM_W-1:0]   q_mem [ALPHA];
  logic [ADDR_W-1:0]  head_r, head_nxt;
  logic [ADDR_W-1:0]  tail_r, tail_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [SYM_W-1:0]   rd_q_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q_mem[tail_r] <= ctl.push_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= q_mem[head_r];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    level_nxt = level_r;
    if (ctl.clr) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      level_nxt = '0;
    end else if (ctl.push) begin
      tail_nxt  = tail_r + ADDR_W'(1);
      level_nxt = level_r + LEVEL_W'(1);
    end else if (ctl.pop) begin
      head_nxt  = head_r + ADDR_W'(1);
      level_nxt = level_r - LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      level_r <= level_nxt;
    end
  end

  assign sts.level   = level_r;
  assign sts.rd_data = rd_q_r;

endmodule

### sv/fnrs_ctrl.sv
// Sequencer: counts the symbol, pushes first occurrences, drops repeated fronts.
module fnrs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_req,
  input  logic [fnrs_pkg::SYM_W-1:0]   in_symbol,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [fnrs_pkg::SYM_W-1:0]   out_first_unique,
  output fnrs_pkg::fnrs_cnt_ctl_t      cnt_ctl,
  input  logic [fnrs_pkg::CNT_W-1:0]   cnt_rd,
  output fnrs_pkg::fnrs_q_ctl_t        q_ctl,
  input  fnrs_pkg::fnrs_q_sts_t        q_sts
);
  import fnrs_pkg::*;

  fnrs_state_t        state_r, state_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               res_found_r, res_found_nxt;
  logic [SYM_W-1:0]   res_sym_r, res_sym_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic [CNT_W-1:0]   cnt_inc;
  logic               do_push;
  logic [LEVEL_W-1:0] level_after;

  always_comb begin
    cnt_inc     = (cnt_rd == CNT_MAX) ? CNT_MAX : cnt_rd + CNT_W'(1);
    do_push     = (cnt_inc == CNT_ONE) && !q_sts.level[LEVEL_W-1];
    level_after = do_push ? q_sts.level + LEVEL_W'(1) : q_sts.level;
  end

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    res_found_nxt = res_found_r;
    res_sym_nxt   = res_sym_r;
    in_ready      = 1'b0;
    cnt_ctl       = '0;
    q_ctl         = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_sym_nxt   = out_sym_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_ctl.clr     = in_start_req;
          q_ctl.clr       = in_start_req;
          cnt_ctl.rd_en   = 1'b1;
          cnt_ctl.rd_addr = in_symbol;
          sym_nxt         = in_symbol;
          state_nxt       = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cnt_ctl.wr_en   = 1'b1;
        cnt_ctl.wr_addr = sym_r;
        cnt_ctl.wr_data = cnt_inc;
        q_ctl.push      = do_push;
        q_ctl.push_data = sym_r;
        if (level_after != '0) begin
          state_nxt = ST_QRD;
        end else begin
          res_found_nxt = 1'b0;
          res_sym_nxt   = NOT_FOUND;
          state_nxt     = ST_DONE;
        end
      end
      ST_QRD: begin
        q_ctl.rd_en = 1'b1;
        state_nxt   = ST_CRD;
      end
      ST_CRD: begin
        cnt_ctl.rd_en   = 1'b1;
        cnt_ctl.rd_addr = q_sts.rd_data;
        state_nxt       = ST_TEST;
      end
      ST_TEST: begin
        if (cnt_rd > CNT_ONE) begin
          // drop the repeated front, then look at the next one
          q_ctl.pop = 1'b1;
          if (q_sts.level == LEVEL_W'(1)) begin
            res_found_nxt = 1'b0;
            res_sym_nxt   = NOT_FOUND;
            state_nxt     = ST_DONE;
          end else begin
            state_nxt = ST_QRD;
          end
        end else begin
          res_found_nxt = 1'b1;
          res_sym_nxt   = q_sts.rd_data;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_sym_nxt   = res_sym_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    res_found_r <= res_found_nxt;
    res_sym_r   <= res_sym_nxt;
    out_found_r <= out_found_nxt;
    out_sym_r   <= out_sym_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_first_unique = out_sym_r;

endmodule

### sv/first_non_repeating_symbol.sv
// Top level of the first non-repeating symbol block.
//
//   channel  | ports                                     | dir
//   ---------+-------------------------------------------+-----
//   in       | in_valid, in_ready, in_start_req, in_symbol | in
//   out      | out_valid, out_ready, out_found, out_first_unique | out
//
// A transaction runs from accept through ST_COUNT, then ST_QRD, ST_CRD and ST_TEST
// per queue front tested (the surviving front and every dropped repeat), to ST_DONE.
// The tests are serialized through the single read port of each memory.
// ST_DONE loads the result into the output register; only ST_IDLE accepts.
// Reset clears the counts at once through per-symbol valid bits; no sweep.
// A start request clears counts and queue in the cycle the symbol is accepted.
// A stalled result sits in the output register; the next symbol is accepted
// meanwhile and its result waits until that register frees up.
module first_non_repeating_symbol (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_start_req,
  input  logic [fnrs_pkg::SYM_W-1:0] in_symbol,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [fnrs_pkg::SYM_W-1:0] out_first_unique
);
  import fnrs_pkg::*;

  fnrs_cnt_ctl_t    cnt_ctl;
  logic [CNT_W-1:0] cnt_rd;
  fnrs_q_ctl_t      q_ctl;
  fnrs_q_sts_t      q_sts;

  fnrs_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_req     (in_start_req),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_first_unique (out_first_unique),
    .cnt_ctl          (cnt_ctl),
    .cnt_rd           (cnt_rd),
    .q_ctl            (q_ctl),
    .q_sts            (q_sts)
  );

  fnrs_count_mem u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cnt_ctl),
    .rd_data (cnt_rd)
  );

  fnrs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .sts   (q_sts)
  );

endmodule

### sv/fnrs_checker.sv
// Port-level checker for the first non-repeating symbol block, with its bind.
module fnrs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_start_req,
  input logic [fnrs_pkg::SYM_W-1:0] in_symbol,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic [fnrs_pkg::SYM_W-1:0] out_first_unique
);
  import fnrs_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_first_unique))
    else $error("stalled result changed");

  // busy after each accepted transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  a_not_found_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_first_unique == NOT_FOUND)
    else $error("not-found result without its code");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result does not appear straight after an accept made while no result was pending
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result one cycle after accept");

endmodule

bind first_non_repeating_symbol fnrs_checker u_fnrs_checker (.*);

### verif/first_unique_checker.sv
// Checker for the first non-repeating symbol block: tracks both channels and predicts answers.
`timescale 1ns / 1ps

module first_unique_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_start_req,
  input  logic [fnrs_pkg::SYM_W-1:0] in_symbol,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_found,
  input  logic [fnrs_pkg::SYM_W-1:0] out_first_unique,
  output int                         mismatch_count,
  output int                         pending_answers,
  output int                         answers_checked
);

  import fnrs_pkg::*;

  localparam int EXP_DEPTH = 256;

  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] first_unique;
  } answer_t;

  // Shadow copy of the per-string state
  logic [CNT_W-1:0]   symbol_tally [ALPHA];
  logic [SYM_W-1:0]   arrival_order [ALPHA];
  logic [ADDR_W-1:0]  order_head;
  logic [ADDR_W-1:0]  order_tail;
  logic [LEVEL_W-1:0] order_level;

  // Expected answers in acceptance order
  answer_t    expected_answers [EXP_DEPTH];
  logic [7:0] exp_rd_ptr;
  logic [7:0] exp_wr_ptr;
  int         exp_held;

  function automatic void clear_string();
    for (int n = 0; n < ALPHA; n++) begin
      symbol_tally[n] = '0;
    end
    order_head  = '0;
    order_tail  = '0;
    order_level = '0;
  endfunction

  function automatic answer_t take_symbol(input logic start, input logic [SYM_W-1:0] sym);
    answer_t ans;
    if (start) clear_string();
    if (symbol_tally[sym] != CNT_MAX) symbol_tally[sym] = symbol_tally[sym] + 1'b1;
    // queue a symbol on its first occurrence only
    if (symbol_tally[sym] == CNT_ONE && order_level < ALPHA) begin
      arrival_order[order_tail] = sym;
      order_tail  = order_tail + 1'b1;
      order_level = order_level + 1'b1;
    end
    // drop front entries that now repeat
    while (order_level != 0 && symbol_tally[arrival_order[order_head]] > CNT_ONE) begin
      order_head  = order_head + 1'b1;
      order_level = order_level - 1'b1;
    end
    if (order_level != 0) begin
      ans.found        = 1'b1;
      ans.first_unique = arrival_order[order_head];
    end else begin
      ans.found        = 1'b0;
      ans.first_unique = NOT_FOUND;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      clear_string();
      exp_rd_ptr = '0;
      exp_wr_ptr = '0;
      exp_held   = 0;
      mismatch_count  <= 0;
      pending_answers <= 0;
      answers_checked <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_held == 0) begin
          mismatch_count <= mismatch_count + 1;
          $display("%0t: unexpected transaction: found %0b first_unique %0d", $time,
                   out_found, out_first_unique);
        end else begin
          want       = expected_answers[exp_rd_ptr];
          exp_rd_ptr = exp_rd_ptr + 8'd1;
          exp_held   = exp_held - 1;
          if (out_found !== want.found || out_first_unique !== want.first_unique) begin
            mismatch_count <= mismatch_count + 1;
            if (out_found !== want.found)
              $display("%0t: found mismatch: expected %0b, actual %0b", $time,
                       want.found, out_found);
            if (out_first_unique !== want.first_unique)
              $display("%0t: first_unique mismatch: expected %0d, actual %0d", $time,
                       want.first_unique, out_first_unique);
          end
        end
        answers_checked <= answers_checked + 1;
      end
      if (in_valid && in_ready) begin
        expected_answers[exp_wr_ptr] = take_symbol(in_start_req, in_symbol);
        exp_wr_ptr = exp_wr_ptr + 8'd1;
        exp_held   = exp_held + 1;
      end
      pending_answers <= exp_held;
    end
  end

endmodule

### verif/first_non_repeating_symbol_test.sv
// Testbench top for the first non-repeating symbol block: stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module first_non_repeating_symbol_test;

  import fnrs_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int SYMBOL_GOAL = 700;
  localparam int LONG_HOLD   = 400;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_start_req;
  logic [SYM_W-1:0] in_symbol;
  logic             out_valid;
  logic             out_ready;
  logic             out_found;
  logic [SYM_W-1:0] out_first_unique;

  int mismatch_count;
  int pending_answers;
  int answers_checked;
  int sent_count;
  int string_count;
  int cascade_count;
  int idle_cycles;
  bit quiet_sender;
  bit eager_receiver;

  always #4 clk = ~clk;

  first_non_repeating_symbol dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_req     (in_start_req),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_first_unique (out_first_unique)
  );

  first_unique_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_req     (in_start_req),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_first_unique (out_first_unique),
    .mismatch_count   (mismatch_count),
    .pending_answers  (pending_answers),
    .answers_checked  (answers_checked)
  );

  // Offer one symbol and hold it until it is accepted
  task automatic offer_symbol(input logic start, input logic [SYM_W-1:0] sym);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_symbol    <= sym;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (start) string_count++;
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers != 0);
  endtask

  initial begin
    logic [SYM_W-1:0] shuffled [ALPHA];
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] tmp;
    int               len;
    int               span;
    int               j;
    bit               drained;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_start_req <= 1'b0;
    in_symbol    <= '0;
    drained      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, '#' as a real symbol, saturation, restarts
    offer_symbol(1'b1, 8'd0);
    offer_symbol(1'b0, 8'd255);
    offer_symbol(1'b0, 8'd0);
    offer_symbol(1'b0, NOT_FOUND);
    offer_symbol(1'b0, 8'd255);
    offer_symbol(1'b0, NOT_FOUND);
    offer_symbol(1'b0, NOT_FOUND);
    offer_symbol(1'b0, NOT_FOUND);
    offer_symbol(1'b0, 8'hAA);
    offer_symbol(1'b0, 8'h55);
    offer_symbol(1'b1, 8'hAA);
    offer_symbol(1'b1, NOT_FOUND);
    offer_symbol(1'b1, 8'h80);
    offer_symbol(1'b0, 8'h7F);
    offer_symbol(1'b0, 8'h01);
    offer_symbol(1'b0, 8'hFE);
    offer_symbol(1'b0, 8'h80);
    offer_symbol(1'b0, 8'h7F);
    offer_symbol(1'b0, 8'h01);
    offer_symbol(1'b0, 8'hFE);
    offer_symbol(1'b1, 8'd255);
    offer_symbol(1'b1, 8'd255);

    // Whole alphabet in one string fills the order queue, then a long cascade
    for (int n = 0; n < ALPHA; n++) shuffled[n] = n[SYM_W-1:0];
    for (int n = ALPHA - 1; n > 0; n--) begin
      j = $urandom_range(0, n);
      tmp = shuffled[n];
      shuffled[n] = shuffled[j];
      shuffled[j] = tmp;
    end
    quiet_sender = 1'b1;
    for (int n = 0; n < ALPHA; n++) offer_symbol(n == 0, shuffled[n]);
    quiet_sender = 1'b0;
    for (int n = 1; n < 10; n++) offer_symbol(1'b0, shuffled[n]);
    offer_symbol(1'b0, shuffled[0]);
    cascade_count++;

    while (sent_count < SYMBOL_GOAL) begin
      if (!drained && sent_count >= 450) begin
        drained = 1'b1;
        drain_answers();
      end
      quiet_sender = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // string from a narrow or wide window of symbols
          len  = $urandom_range(1, 40);
          base = SYM_W'($urandom_range(0, 255));
          case ($urandom_range(0, 4))
            0:       span = 1;
            1:       span = 3;
            2:       span = 7;
            3:       span = 15;
            default: span = 255;
          endcase
          for (int n = 0; n < len; n++)
            offer_symbol(n == 0 || $urandom_range(0, 29) == 0,
                         SYM_W'(base + $urandom_range(0, span)));
        end
        6, 7, 8: begin
          // distinct symbols, repeat all but the front, then the front
          len  = $urandom_range(2, 30);
          base = SYM_W'($urandom_range(0, 255));
          for (int n = 0; n < len; n++) offer_symbol(n == 0, SYM_W'(base + n));
          for (int n = 1; n < len; n++) offer_symbol(1'b0, SYM_W'(base + n));
          offer_symbol(1'b0, base);
          cascade_count++;
        end
        default: begin
          len = $urandom_range(1, 20);
          for (int n = 0; n < len; n++)
            offer_symbol(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)));
        end
      endcase
    end

    drain_answers();
    repeat (20) @(posedge clk);
    $display("Run covered %0d symbols in %0d strings with %0d drop cascades,", sent_count,
             string_count, cascade_count);
    $display("a full-alphabet string and a long output stall; %0d answers checked.",
             answers_checked);
    if (mismatch_count == 0 && pending_answers == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random waits, eager stretches, one long hold-off
  initial begin
    int wait_cycles;
    int taken;
    taken          = 0;
    eager_receiver = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 150) wait_cycles = LONG_HOLD;
      else if (eager_receiver) wait_cycles = 0;
      else wait_cycles = $urandom_range(0, 12);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 40 == 0) eager_receiver = ($urandom_range(0, 3) == 0);
    end
  end

  // Stop a hung run: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

### filelist.f
sv/fnrs_pkg.sv
sv/fnrs_count_mem.sv
sv/fnrs_queue.sv
sv/fnrs_ctrl.sv
sv/first_non_repeating_symbol.sv
sv/fnrs_checker.sv
verif/first_unique_checker.sv
verif/first_non_repeating_symbol_test.sv
